>>> rtl/elfr_pkg.sv
// Package for the escaped length frame receiver.
// Holds phase, byte class, status and register codes, reset values and the result type.
// Depends on nothing; used by the top level and the testbench.
package elfr_pkg;

   localparam int unsigned ADDR_WIDTH = 4;
   localparam int unsigned DATA_WIDTH = 32;

   localparam logic [1:0] REG_START_SYMBOL  = 2'd0;
   localparam logic [1:0] REG_ESCAPE_SYMBOL = 2'd1;
   localparam logic [1:0] REG_MAX_LENGTH    = 2'd2;

   localparam logic [7:0]  START_SYMBOL_RESET  = 8'd126;
   localparam logic [7:0]  ESCAPE_SYMBOL_RESET = 8'd125;
   localparam logic [15:0] MAX_LENGTH_RESET    = 16'hFFFF;

   localparam logic [1:0] PH_HUNT    = 2'd0;
   localparam logic [1:0] PH_LEN_LO  = 2'd1;
   localparam logic [1:0] PH_LEN_HI  = 2'd2;
   localparam logic [1:0] PH_PAYLOAD = 2'd3;

   localparam logic [1:0] CLS_NONE  = 2'd0;
   localparam logic [1:0] CLS_START = 2'd1;
   localparam logic [1:0] CLS_DATA  = 2'd2;
   localparam logic [1:0] CLS_BAD   = 2'd3;

   localparam logic [1:0] STATUS_NONE   = 2'd0;
   localparam logic [1:0] STATUS_DONE   = 2'd1;
   localparam logic [1:0] STATUS_BROKEN = 2'd2;

   typedef struct packed {
      logic [1:0]  frame_status;
      logic        payload_valid;
      logic [7:0]  payload_byte;
      logic [15:0] payload_index;
      logic [15:0] frame_length;
   } rsp_type;

endpackage

>>> rtl/elfr_if.sv
// Valid/ready channel interfaces of the escaped length frame receiver.
// elfr_req_if carries received bytes, elfr_rsp_if carries per-byte results.
// No dependencies.
interface elfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface elfr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  frame_status;
   logic        payload_valid;
   logic [7:0]  payload_byte;
   logic [15:0] payload_index;
   logic [15:0] frame_length;

   modport source (output valid, output frame_status, output payload_valid,
                   output payload_byte, output payload_index, output frame_length,
                   input ready);
   modport sink (input valid, input frame_status, input payload_valid,
                 input payload_byte, input payload_index, input frame_length,
                 output ready);
endinterface

>>> rtl/escaped_length_frame_receiver.sv
// Top level of the escaped length frame receiver: deframer state, result register, CSRs.
// Depends on elfr_pkg and the channel interfaces in elfr_if.sv.
//
// Takes one link byte per beat and returns exactly one result beat per byte, one byte per
// clock cycle sustained. Each byte updates the deframer state in the cycle it is accepted;
// its result sits in a single output register and appears in the following cycle. A new byte is
// taken while a result is waiting as long as the result is drained in the same cycle, so
// only back-pressure on the result side slows the input. Results report payload bytes with
// their index, and frame completion or breakage on the byte that decides it. Registers
// (start symbol at 0x0, escape symbol at 0x4, max length at 0x8) must be written by the user
// through the APB-style port only while no byte is in flight; the block does not enforce this.
module escaped_length_frame_receiver (
   input  logic                            clock,
   input  logic                            reset,
   elfr_req_if.sink                        req_bus,
   elfr_rsp_if.source                      rsp_bus,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [elfr_pkg::ADDR_WIDTH-1:0] csr_paddr,
   input  logic [elfr_pkg::DATA_WIDTH-1:0] csr_pwdata,
   output logic [elfr_pkg::DATA_WIDTH-1:0] csr_prdata,
   output logic                            csr_pready
);

   logic [7:0]  start_symbol_ff;
   logic [7:0]  escape_symbol_ff;
   logic [15:0] max_length_ff;

   logic [1:0]  phase_ff, phase_in;
   logic        esc_pending_ff, esc_pending_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] count_ff, count_in;

   logic                  out_valid_ff;
   elfr_pkg::rsp_type     out_ff, out_in;

   logic        accept;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic [1:0]  cls;
   logic [7:0]  b;
   logic [15:0] len_full;
   logic [15:0] count_inc;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         start_symbol_ff  <= elfr_pkg::START_SYMBOL_RESET;
         escape_symbol_ff <= elfr_pkg::ESCAPE_SYMBOL_RESET;
         max_length_ff    <= elfr_pkg::MAX_LENGTH_RESET;
      end else if (csr_write) begin
         case (csr_index)
            elfr_pkg::REG_START_SYMBOL:  start_symbol_ff  <= csr_pwdata[7:0];
            elfr_pkg::REG_ESCAPE_SYMBOL: escape_symbol_ff <= csr_pwdata[7:0];
            elfr_pkg::REG_MAX_LENGTH:    max_length_ff    <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         elfr_pkg::REG_START_SYMBOL:  csr_prdata = {24'd0, start_symbol_ff};
         elfr_pkg::REG_ESCAPE_SYMBOL: csr_prdata = {24'd0, escape_symbol_ff};
         elfr_pkg::REG_MAX_LENGTH:    csr_prdata = {16'd0, max_length_ff};
         default:                     csr_prdata = '0;
      endcase
   end

   assign req_bus.ready = !out_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign b             = req_bus.rx_byte;
   assign len_full      = {b, length_ff[7:0]};
   assign count_inc     = count_ff + 16'd1;

   always_comb begin
      esc_pending_in = 1'b0;
      if (esc_pending_ff) begin
         cls = (b == escape_symbol_ff || b == start_symbol_ff) ?
               elfr_pkg::CLS_DATA : elfr_pkg::CLS_BAD;
      end else if (b == escape_symbol_ff) begin
         cls            = elfr_pkg::CLS_NONE;
         esc_pending_in = 1'b1;
      end else if (b == start_symbol_ff) begin
         cls = elfr_pkg::CLS_START;
      end else begin
         cls = elfr_pkg::CLS_DATA;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      length_in = length_ff;
      count_in  = count_ff;
      out_in    = '0;
      case (phase_ff)
         elfr_pkg::PH_HUNT: begin
            if (cls == elfr_pkg::CLS_START) phase_in = elfr_pkg::PH_LEN_LO;
         end
         elfr_pkg::PH_LEN_LO: begin
            if (cls == elfr_pkg::CLS_DATA) begin
               length_in = {8'd0, b};
               phase_in  = elfr_pkg::PH_LEN_HI;
            end else if (cls != elfr_pkg::CLS_NONE) begin
               phase_in            = elfr_pkg::PH_HUNT;
               out_in.frame_status = elfr_pkg::STATUS_BROKEN;
            end
         end
         elfr_pkg::PH_LEN_HI: begin
            if (cls == elfr_pkg::CLS_DATA) begin
               length_in = len_full;
               count_in  = '0;
               if (len_full > max_length_ff) begin
                  phase_in            = elfr_pkg::PH_HUNT;
                  out_in.frame_status = elfr_pkg::STATUS_BROKEN;
               end else if (len_full == 16'd0) begin
                  phase_in            = elfr_pkg::PH_HUNT;
                  out_in.frame_status = elfr_pkg::STATUS_DONE;
               end else begin
                  phase_in = elfr_pkg::PH_PAYLOAD;
               end
            end else if (cls != elfr_pkg::CLS_NONE) begin
               phase_in            = elfr_pkg::PH_HUNT;
               out_in.frame_status = elfr_pkg::STATUS_BROKEN;
            end
         end
         default: begin
            if (cls == elfr_pkg::CLS_DATA) begin
               out_in.payload_valid = 1'b1;
               out_in.payload_byte  = b;
               out_in.payload_index = count_ff;
               count_in             = count_inc;
               if (count_inc == length_ff) begin
                  phase_in            = elfr_pkg::PH_HUNT;
                  out_in.frame_status = elfr_pkg::STATUS_DONE;
               end
            end else if (cls != elfr_pkg::CLS_NONE) begin
               phase_in            = elfr_pkg::PH_HUNT;
               out_in.frame_status = elfr_pkg::STATUS_BROKEN;
            end
         end
      endcase
      out_in.frame_length = length_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= elfr_pkg::PH_HUNT;
         esc_pending_ff <= 1'b0;
         length_ff      <= '0;
         count_ff       <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff       <= phase_in;
            esc_pending_ff <= esc_pending_in;
            length_ff      <= length_in;
            count_ff       <= count_in;
            out_valid_ff   <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) out_ff <= out_in;
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.frame_status  = out_ff.frame_status;
   assign rsp_bus.payload_valid = out_ff.payload_valid;
   assign rsp_bus.payload_byte  = out_ff.payload_byte;
   assign rsp_bus.payload_index = out_ff.payload_index;
   assign rsp_bus.frame_length  = out_ff.frame_length;

endmodule

>>> test/escaped_length_frame_receiver_tb.sv
// Testbench for escaped_length_frame_receiver: byte stream in, one result beat per byte out.
// A built-in deframer predicts every result beat; the CSRs are changed between bursts.
// Depends on elfr_pkg, the channel interfaces in elfr_if.sv and the RTL top level.
module escaped_length_frame_receiver_tb;
   import elfr_pkg::*;

   localparam int LONG_HOLD    = 60;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PRINT_LIMIT  = 50;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [ADDR_WIDTH-1:0] csr_paddr   = '0;
   logic [DATA_WIDTH-1:0] csr_pwdata  = '0;
   logic [DATA_WIDTH-1:0] csr_prdata;
   logic                  csr_pready;

   elfr_req_if req_bus();
   elfr_rsp_if rsp_bus();

   escaped_length_frame_receiver i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // deframer copy: symbols, limit and receive state
   logic [7:0]  cfg_start   = START_SYMBOL_RESET;
   logic [7:0]  cfg_escape  = ESCAPE_SYMBOL_RESET;
   logic [15:0] cfg_max_len = MAX_LENGTH_RESET;
   logic [1:0]  fr_phase    = PH_HUNT;
   logic        esc_pending = 1'b0;
   logic [15:0] len_q       = '0;
   logic [15:0] pay_count   = '0;

   rsp_type    expected_beats[$];
   logic [7:0] link_bytes[$];

   int bytes_queued   = 0;
   int results_seen   = 0;
   int errors         = 0;
   int frames_done    = 0;
   int frames_broken  = 0;
   int send_idle_pct  = 36;
   int recv_stall_pct = 69;
   int hold_ticket    = 0;
   int hold_taken     = 0;
   int hold_left      = 0;
   int cycles         = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_type deframe_byte(logic [7:0] b);
      rsp_type    r;
      logic [1:0] cls;
      r = '0;
      if (esc_pending) begin
         esc_pending = 1'b0;
         cls = (b == cfg_escape || b == cfg_start) ? CLS_DATA : CLS_BAD;
      end else if (b == cfg_escape) begin
         esc_pending = 1'b1;
         cls = CLS_NONE;
      end else if (b == cfg_start) begin
         cls = CLS_START;
      end else begin
         cls = CLS_DATA;
      end
      case (fr_phase)
         PH_HUNT: begin
            if (cls == CLS_START) fr_phase = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            if (cls == CLS_DATA) begin
               len_q = {8'h00, b};
               fr_phase = PH_LEN_HI;
            end else if (cls == CLS_START || cls == CLS_BAD) begin
               fr_phase = PH_HUNT;
               r.frame_status = STATUS_BROKEN;
            end
         end
         PH_LEN_HI: begin
            if (cls == CLS_DATA) begin
               len_q = {b, len_q[7:0]};
               pay_count = '0;
               fr_phase = PH_PAYLOAD;
               if (len_q > cfg_max_len) begin
                  fr_phase = PH_HUNT;
                  r.frame_status = STATUS_BROKEN;
               end else if (len_q == 16'd0) begin
                  fr_phase = PH_HUNT;
                  r.frame_status = STATUS_DONE;
               end
            end else if (cls == CLS_START || cls == CLS_BAD) begin
               fr_phase = PH_HUNT;
               r.frame_status = STATUS_BROKEN;
            end
         end
         default: begin
            if (cls == CLS_DATA) begin
               r.payload_valid = 1'b1;
               r.payload_byte  = b;
               r.payload_index = pay_count;
               pay_count = pay_count + 16'd1;
               if (pay_count == len_q) begin
                  fr_phase = PH_HUNT;
                  r.frame_status = STATUS_DONE;
               end
            end else if (cls == CLS_START || cls == CLS_BAD) begin
               fr_phase = PH_HUNT;
               r.frame_status = STATUS_BROKEN;
            end
         end
      endcase
      r.frame_length = len_q;
      return r;
   endfunction

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      errors++;
      if (errors <= PRINT_LIMIT)
         $display("MISMATCH beat %0d %s: got 0x%0h expected 0x%0h",
                  results_seen, what, got, want);
   endtask

   // byte sender
   always @(posedge clock) begin
      rsp_type predicted;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predicted = deframe_byte(req_bus.rx_byte);
            if (predicted.frame_status == STATUS_DONE) frames_done++;
            if (predicted.frame_status == STATUS_BROKEN) frames_broken++;
            expected_beats.push_back(predicted);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (link_bytes.size() > 0 && int'($urandom_range(99)) >= send_idle_pct) begin
               req_bus.valid   <= 1'b1;
               req_bus.rx_byte <= link_bytes.pop_front();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result checker and receiver back-pressure
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (expected_beats.size() == 0) begin
               report_mismatch("beat with nothing expected", rsp_bus.frame_status, 0);
            end else begin
               want = expected_beats.pop_front();
               if (rsp_bus.frame_status != want.frame_status)
                  report_mismatch("frame_status", rsp_bus.frame_status, want.frame_status);
               if (rsp_bus.payload_valid != want.payload_valid)
                  report_mismatch("payload_valid", rsp_bus.payload_valid, want.payload_valid);
               if (rsp_bus.payload_byte != want.payload_byte)
                  report_mismatch("payload_byte", rsp_bus.payload_byte, want.payload_byte);
               if (rsp_bus.payload_index != want.payload_index)
                  report_mismatch("payload_index", rsp_bus.payload_index, want.payload_index);
               if (rsp_bus.frame_length != want.frame_length)
                  report_mismatch("frame_length", rsp_bus.frame_length, want.frame_length);
            end
         end
         if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            rsp_bus.ready <= 1'b0;
         end else if (hold_ticket != hold_taken) begin
            hold_taken    <= hold_ticket;
            hold_left     <= LONG_HOLD;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= int'($urandom_range(99)) >= recv_stall_pct;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("run timed out after %0d cycles", cycles);
         $display("tb: failure");
         $finish;
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [15:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_WIDTH'({idx, 2'b00});
      csr_pwdata  <= DATA_WIDTH'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_START_SYMBOL:  cfg_start   = value[7:0];
         REG_ESCAPE_SYMBOL: cfg_escape  = value[7:0];
         default:           cfg_max_len = value;
      endcase
   endtask

   task automatic put_raw(logic [7:0] b);
      link_bytes.push_back(b);
      bytes_queued++;
   endtask

   task automatic put_literal(logic [7:0] b);
      if (b == cfg_start || b == cfg_escape) put_raw(cfg_escape);
      put_raw(b);
   endtask

   task automatic put_frame(logic [15:0] len, int unsigned body);
      put_raw(cfg_start);
      put_literal(len[7:0]);
      put_literal(len[15:8]);
      for (int unsigned i = 0; i < body; i++) put_literal(8'($urandom_range(255)));
   endtask

   // unexpected start or invalid escape pair
   task automatic put_breaker();
      logic [7:0] b;
      if ($urandom_range(1)) begin
         put_raw(cfg_start);
      end else begin
         put_raw(cfg_escape);
         do b = 8'($urandom_range(255)); while (b == cfg_start || b == cfg_escape);
         put_raw(b);
      end
   endtask

   function automatic logic [15:0] pick_len();
      int unsigned cap;
      cap = ($urandom_range(9) == 0) ? 48 : 8;
      if (cfg_max_len < cap) cap = cfg_max_len;
      return 16'($urandom_range(cap));
   endfunction

   task automatic wait_quiet();
      while (results_seen < bytes_queued) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int          goal;
      int          sel;
      logic [7:0]  s;
      logic [7:0]  e;
      logic [15:0] m;
      logic [15:0] len;
      req_bus.valid   = 1'b0;
      req_bus.rx_byte = 8'h00;
      rsp_bus.ready   = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      put_frame(16'd0, 0);
      put_raw(cfg_start); put_raw(8'h02); put_raw(8'h00);
      put_literal(cfg_start); put_literal(cfg_escape);
      put_literal(cfg_start);
      put_raw(cfg_start); put_raw(8'hFF); put_raw(8'hFF); put_raw(cfg_start);
      put_raw(cfg_start); put_raw(cfg_escape); put_raw(8'h00);
      put_raw(8'h00); put_raw(8'hFF);
      put_raw(cfg_start); put_raw(8'h01); put_raw(8'h00); put_raw(8'hFF);

      for (int p = 0; p < 8; p++) begin
         wait_quiet();
         s = 8'($urandom_range(255));
         do e = 8'($urandom_range(255)); while (e == s);
         case (p)
            0: begin s = 8'h00; e = 8'hFF; m = 16'h0000; end
            1: begin s = 8'hFF; e = 8'h00; m = 16'hFFFF; end
            2: begin s = 8'h55; e = 8'h55; m = 16'd12; end
            3: begin s = START_SYMBOL_RESET; e = ESCAPE_SYMBOL_RESET; m = 16'd3; end
            4: m = 16'($urandom_range(40));
            5: m = 16'hFFFF;
            6: begin s = START_SYMBOL_RESET; e = ESCAPE_SYMBOL_RESET; m = 16'd30; end
            default: m = 16'($urandom_range(1, 64));
         endcase
         write_reg(REG_START_SYMBOL, {8'h00, s});
         write_reg(REG_ESCAPE_SYMBOL, {8'h00, e});
         write_reg(REG_MAX_LENGTH, m);
         if (p >= 6) begin
            send_idle_pct = 0;  recv_stall_pct = 0;
         end else if (p >= 3) begin
            send_idle_pct = 69; recv_stall_pct = 36;
         end

         goal = bytes_queued + 110;
         while (bytes_queued < goal) begin
            sel = $urandom_range(99);
            if (sel < 65) begin
               len = pick_len();
               put_frame(len, len);
            end else if (sel < 75) begin
               if (cfg_max_len == 16'hFFFF) begin
                  len = pick_len();
                  put_frame(len, len);
               end else begin
                  len = 16'($urandom_range(int'(cfg_max_len) + 1, 65535));
                  put_frame(len, 0);
               end
            end else if (sel < 85) begin
               len = pick_len() + 16'd1;
               put_frame(len, $urandom_range(int'(len) - 1));
               put_breaker();
            end else if (sel < 90) begin
               put_raw(cfg_start);
               if ($urandom_range(1)) put_literal(8'($urandom_range(255)));
               put_breaker();
            end else begin
               repeat ($urandom_range(1, 4)) put_raw(8'($urandom_range(255)));
            end
         end
         // receiver holds off while a full burst is offered
         if (p == 6) begin
            @(posedge clock);
            hold_ticket <= hold_ticket + 1;
         end
      end

      wait_quiet();
      if (expected_beats.size() != 0)
         report_mismatch("results never returned", expected_beats.size(), 0);
      $display("covered %0d link bytes under 9 symbol settings, max_length 0 to 65535",
               bytes_queued);
      $display("predicted %0d completed and %0d broken frames", frames_done, frames_broken);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
